// ===== rtl/ppsu_pkg.sv =====
// Shared constants for the pure pursuit steering unit.
// Holds the CORDIC arctangent table and the fixed-point constants; no dependencies.
package ppsu_pkg;

	localparam int ATAN_LEN = 24;

	// Arctangent of 2^-i in turns scaled by 2^32.
	localparam logic [31:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic signed [24:0] CORDIC_GAIN_Q24 = 25'sd10188014;
	localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;

	localparam logic [1:0] REG_STOP_RADIUS   = 2'd0;
	localparam logic [1:0] REG_CRUISE_SPEED  = 2'd1;
	localparam logic [1:0] REG_AXLE_DISTANCE = 2'd2;

endpackage

// ===== rtl/ppsu_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
// Depends on ppsu_pkg for the arctangent table.
module ppsu_cordic #(
	parameter int STAGES = 16,
	parameter int W = 36,
	parameter int SIDE_W = 1,
	parameter bit VECTORING = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic signed [W-1:0] z_in,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic signed [W-1:0] res,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int N = (STAGES < ppsu_pkg::ATAN_LEN) ? STAGES : ppsu_pkg::ATAN_LEN;

	logic                v_s  [0:N];
	logic signed [W-1:0] x_s  [0:N];
	logic signed [W-1:0] y_s  [0:N];
	logic signed [W-1:0] z_s  [0:N];
	logic [SIDE_W-1:0]   sd_s [0:N];

	assign v_s[0]  = in_valid;
	assign x_s[0]  = x_in;
	assign y_s[0]  = y_in;
	assign z_s[0]  = z_in;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [W-1:0] ang;
		logic                up;
		assign ang = $signed({{(W-32){1'b0}}, ppsu_pkg::ATAN_TURNS[i]});
		// Rotate counterclockwise when the residual angle is non-negative, or when the
		// vector still points below the axis in vectoring mode.
		assign up = VECTORING ? y_s[i][W-1] : !z_s[i][W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_s[i];
				if (up) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ang;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ang;
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign res       = VECTORING ? z_s[N] : y_s[N];
	assign side_out  = sd_s[N];

endmodule

// ===== rtl/pure_pursuit_steering_unit.sv =====
// Top level of the pure pursuit steering unit.
// Depends on ppsu_pkg and ppsu_cordic.
//
// Usage: one goal/pose transfer on the s_ stream yields exactly one command
// transfer on the m_ stream, in order. The input tdata carries goal_x, goal_y,
// pose_x, pose_y (signed Q16.16) and pose_heading (binary angle). The output
// carries speed_cmd, steer_angle and at_goal.
// From input transfer to valid output, three stages form the offset, squares,
// quadrant fold and stop-radius test, the rotation CORDIC follows, three stages
// remove the CORDIC gain and scale by the wheelbase, three stages normalize the
// operands, the vectoring CORDIC follows and a final register rounds and clamps
// the angle.
// Throughput is one transfer per cycle unless stalled; every stage is a register
// with a valid bit. When the receiver stalls with a result pending, the whole
// pipeline freezes and s_tready drops in the same cycle, so nothing is lost or
// repeated. The APB port writes stop_radius, cruise_speed and axle_distance at
// byte addresses 0, 4 and 8; pready is always high. Registers may be written only
// while the pipeline is empty.
// Reset clears all valid bits and loads the register defaults (0.1 m, 0.2 m/s,
// 1.0 m in the FRAC_BITS format). There is no clearing pass.
module pure_pursuit_steering_unit #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// goal_x[31:0], goal_y[63:32], pose_x[95:64], pose_y[127:96], pose_heading[143:128]
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// speed_cmd[23:0], steer_angle[39:24], at_goal[40], zero fill[47:41]
	output logic [47:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int WR = 36;  // rotation datapath width
	localparam int WV = 34;  // vectoring datapath width
	localparam int NST = (CORDIC_STAGES < ppsu_pkg::ATAN_LEN) ? CORDIC_STAGES
		: ppsu_pkg::ATAN_LEN;
	localparam longint unsigned MAX24 = 64'hFFFFFF;
	localparam longint unsigned RAD_RAW = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam longint unsigned SPD_RAW = ((64'd2 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam longint unsigned AXL_RAW = 64'd1 << FRAC_BITS;
	localparam logic [23:0] RAD_RST = 24'((RAD_RAW > MAX24) ? MAX24 : RAD_RAW);
	localparam logic [23:0] SPD_RST = 24'((SPD_RAW > MAX24) ? MAX24 : SPD_RAW);
	localparam logic [23:0] AXL_RST = 24'((AXL_RAW > MAX24) ? MAX24 : AXL_RAW);

	// Configuration registers. The user writes only while the pipeline is empty; not enforced.
	logic [23:0] stop_radius_q, cruise_speed_q, axle_distance_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_radius_q   <= RAD_RST;
			cruise_speed_q  <= SPD_RST;
			axle_distance_q <= AXL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ppsu_pkg::REG_STOP_RADIUS:   stop_radius_q   <= pwdata[23:0];
				ppsu_pkg::REG_CRUISE_SPEED:  cruise_speed_q  <= pwdata[23:0];
				ppsu_pkg::REG_AXLE_DISTANCE: axle_distance_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ppsu_pkg::REG_STOP_RADIUS:   prdata = {8'd0, stop_radius_q};
			ppsu_pkg::REG_CRUISE_SPEED:  prdata = {8'd0, cruise_speed_q};
			ppsu_pkg::REG_AXLE_DISTANCE: prdata = {8'd0, axle_distance_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// The pipeline advances as a whole unless a result waits on a stalled receiver.
	logic m_valid_q;
	logic en;
	assign en = !m_valid_q || m_tready;
	assign s_tready = en;

	// Stage 1: goal offset, saturated to 32 bits, and the inverse heading as a
	// 33-bit turn fraction.
	logic signed [32:0] dx_w, dy_w, z_w;
	logic signed [31:0] dx_s1, dy_s1;
	logic signed [32:0] z_s1;
	logic               v_s1;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
		return v[31:0];
	endfunction

	assign dx_w = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({s_tdata[95], s_tdata[95:64]});
	assign dy_w = $signed({s_tdata[63], s_tdata[63:32]})
		- $signed({s_tdata[127], s_tdata[127:96]});
	assign z_w  = 33'sd0 - $signed({s_tdata[143], s_tdata[143:128], 16'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= sat32(dx_w);
			dy_s1 <= sat32(dy_w);
			z_s1  <= z_w;
		end
	end

	// Stage 2: squares of the offset and the radius, and the quadrant fold that
	// brings the rotation angle within a quarter turn.
	logic [63:0]          sqx_s2, sqy_s2;
	logic [47:0]          r2_s2;
	logic signed [WR-1:0] x_s2, y_s2, zr_s2;
	logic signed [WR-1:0] dxe, dye, ze;
	logic                 v_s2;

	assign dxe = WR'(dx_s1);
	assign dye = WR'(dy_s1);
	assign ze  = WR'(z_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= 64'(64'($signed(dx_s1)) * 64'($signed(dx_s1)));
			sqy_s2 <= 64'(64'($signed(dy_s1)) * 64'($signed(dy_s1)));
			r2_s2  <= 48'(stop_radius_q) * 48'(stop_radius_q);
			if (z_s1 > ppsu_pkg::QUARTER_TURN) begin
				x_s2  <= -dye;
				y_s2  <= dxe;
				zr_s2 <= ze - WR'(ppsu_pkg::QUARTER_TURN);
			end else if (z_s1 < -ppsu_pkg::QUARTER_TURN) begin
				x_s2  <= dye;
				y_s2  <= -dxe;
				zr_s2 <= ze + WR'(ppsu_pkg::QUARTER_TURN);
			end else begin
				x_s2  <= dxe;
				y_s2  <= dye;
				zr_s2 <= ze;
			end
		end
	end

	// Stage 3: squared distance and the stop-radius test.
	logic [63:0]          d2_s3;
	logic                 at_goal_s3;
	logic signed [WR-1:0] x_s3, y_s3, zr_s3;
	logic                 v_s3;
	logic [63:0]          d2_w;

	assign d2_w = sqx_s2 + sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3      <= d2_w;
			at_goal_s3 <= d2_w < {16'd0, r2_s2};
			x_s3       <= x_s2;
			y_s3       <= y_s2;
			zr_s3      <= zr_s2;
		end
	end

	// Rotation CORDIC: local y of the offset, with the CORDIC gain still applied.
	logic                 rot_v;
	logic signed [WR-1:0] rot_y;
	logic [64:0]          rot_side;

	ppsu_cordic #(
		.STAGES   (CORDIC_STAGES),
		.W        (WR),
		.SIDE_W   (65),
		.VECTORING(1'b0)
	) u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.x_in     (x_s3),
		.y_in     (y_s3),
		.z_in     (zr_s3),
		.side_in  ({at_goal_s3, d2_s3}),
		.out_valid(rot_v),
		.res      (rot_y),
		.side_out (rot_side)
	);

	// Stages 4 to 6: gain correction with rounding, then 2 * wheelbase * local y.
	logic signed [60:0]   prod_s4;
	logic signed [WR-1:0] ly_s5;
	logic signed [61:0]   num_s6;
	logic [64:0]          sd_s4, sd_s5, sd_s6;
	logic                 v_s4, v_s5, v_s6;
	logic signed [60:0]   ly_round;

	assign ly_round = (prod_s4 + 61'sd8388608) >>> 24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= rot_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= 61'(rot_y) * 61'(ppsu_pkg::CORDIC_GAIN_Q24);
			sd_s4   <= rot_side;
			ly_s5   <= WR'(ly_round);
			sd_s5   <= sd_s4;
			num_s6  <= (62'(ly_s5) * $signed({38'd0, axle_distance_q})) <<< 1;
			sd_s6   <= sd_s5;
		end
	end

	// Stages 7 to 9: magnitudes, common shift count, joint right shift below 2^30.
	logic [63:0] a_s7, b_s7, a_s8, b_s8;
	logic        neg_s7, nz_s7, ag_s7, neg_s8, nz_s8, ag_s8;
	logic [6:0]  sh_s8;
	logic [6:0]  bitlen;
	logic [63:0] ab_or;
	logic signed [WV-1:0] vx_s9, vy_s9;
	logic        nz_s9, ag_s9;
	logic        v_s7, v_s8, v_s9;
	logic [63:0] a_sh, b_sh;

	always_comb begin
		ab_or  = a_s7 | b_s7;
		bitlen = 7'd0;
		for (int i = 0; i < 64; i++) begin
			if (ab_or[i]) begin
				bitlen = 7'(i + 1);
			end
		end
	end

	assign a_sh = a_s8 >> sh_s8;
	assign b_sh = b_s8 >> sh_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s7   <= 64'(num_s6[61] ? -num_s6 : num_s6);
			b_s7   <= sd_s6[63:0];
			neg_s7 <= num_s6[61];
			nz_s7  <= (sd_s6[63:0] != 64'd0) && (num_s6 != 62'sd0);
			ag_s7  <= sd_s6[64];
			a_s8   <= a_s7;
			b_s8   <= b_s7;
			sh_s8  <= (bitlen > 7'd30) ? bitlen - 7'd30 : 7'd0;
			neg_s8 <= neg_s7;
			nz_s8  <= nz_s7;
			ag_s8  <= ag_s7;
			vx_s9  <= $signed({4'd0, b_sh[29:0]});
			vy_s9  <= neg_s8 ? -$signed({4'd0, a_sh[29:0]}) : $signed({4'd0, a_sh[29:0]});
			nz_s9  <= nz_s8;
			ag_s9  <= ag_s8;
		end
	end

	// Vectoring CORDIC: steering angle as a 32-bit turn fraction.
	logic                 vec_v;
	logic signed [WV-1:0] vec_z;
	logic [1:0]           vec_side;

	ppsu_cordic #(
		.STAGES   (CORDIC_STAGES),
		.W        (WV),
		.SIDE_W   (2),
		.VECTORING(1'b1)
	) u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s9),
		.x_in     (vx_s9),
		.y_in     (vy_s9),
		.z_in     ('0),
		.side_in  ({ag_s9, nz_s9}),
		.out_valid(vec_v),
		.res      (vec_z),
		.side_out (vec_side)
	);

	// Output register: round to 16-bit binary angle, clamp to a quarter turn (zero if nz clear).
	logic signed [WV-1:0] z_round;
	logic signed [15:0]   steer_w;
	logic [23:0]          speed_q;
	logic signed [15:0]   steer_q;
	logic                 at_goal_q;

	assign z_round = (vec_z + WV'(32768)) >>> 16;

	always_comb begin
		if (!vec_side[0]) begin
			steer_w = 16'sd0;
		end else if (z_round > WV'(16384)) begin
			steer_w = 16'sd16384;
		end else if (z_round < -WV'(16384)) begin
			steer_w = -16'sd16384;
		end else begin
			steer_w = z_round[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= vec_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_q   <= vec_side[1] ? 24'd0 : cruise_speed_q;
			steer_q   <= steer_w;
			at_goal_q <= vec_side[1];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, at_goal_q, steer_q, speed_q};

`ifndef ASSERT_OFF
	a_goal_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && at_goal_q |-> speed_q == 24'd0)
		else $error("speed command not zero inside stop radius");
	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (steer_q <= 16'sd16384) && (steer_q >= -16'sd16384))
		else $error("steering angle out of range");
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");
	a_zero_steer: assert property (@(posedge clk) disable iff (!arst_n)
		en && vec_v && !vec_side[0] |=> steer_q == 16'sd0)
		else $error("nonzero steering for zero offset or numerator");
`endif

endmodule

// ===== bench/pure_pursuit_steering_unit_tb.sv =====
// Self-checking bench for the pure pursuit steering unit: streams goal/pose items,
// checks each steering command against a built-in predictor or a fixed one. Depends on
// ppsu_pkg and the RTL of pure_pursuit_steering_unit.
module pure_pursuit_steering_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam int FRAC = 16;
	localparam int LATENCY = 2 * STAGES + 10;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 380;

	typedef struct packed {
		logic [23:0] speed;
		logic signed [15:0] steer;
		logic at_goal;
	} steer_cmd_t;

	typedef struct {
		logic [31:0] gx, gy, px, py;
		logic [15:0] hd;
		bit typed;
		steer_cmd_t cmd;
	} pose_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// goal_x[31:0], goal_y[63:32], pose_x[95:64], pose_y[127:96], pose_heading[143:128]
	logic [143:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// speed_cmd[23:0], steer_angle[39:24], at_goal[40], zero fill[47:41]
	logic [47:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the three registers as the block should hold them.
	logic [23:0] stop_radius_q = 24'd6554;
	logic [23:0] cruise_speed_q = 24'd13107;
	logic [23:0] axle_distance_q = 24'd65536;

	steer_cmd_t pending_cmds[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int at_goal_seen = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	pure_pursuit_steering_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Computes the command for one goal/pose item from the current register shadow.
	function automatic steer_cmd_t steer_predict(logic [143:0] d);
		longint dx, dy, x, y, z, t, xs, ys, ly, num, steer;
		logic [63:0] d2, r2, a, b;
		steer_cmd_t c;
		dx = clip32(longint'($signed(d[31:0])) - longint'($signed(d[95:64])));
		dy = clip32(longint'($signed(d[63:32])) - longint'($signed(d[127:96])));
		d2 = 64'(dx * dx) + 64'(dy * dy);
		r2 = 64'(stop_radius_q) * 64'(stop_radius_q);
		c.at_goal = d2 < r2;
		// Rotate the offset by minus the heading, folding first into the right half-plane.
		x = dx;
		y = dy;
		z = -longint'($signed(d[143:128])) * 65536;
		if (z > longint'(ppsu_pkg::QUARTER_TURN)) begin
			t = x; x = -y; y = t; z -= longint'(ppsu_pkg::QUARTER_TURN);
		end else if (z < -longint'(ppsu_pkg::QUARTER_TURN)) begin
			t = x; x = y; y = -t; z += longint'(ppsu_pkg::QUARTER_TURN);
		end
		for (int i = 0; i < STAGES && i < ppsu_pkg::ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ppsu_pkg::ATAN_TURNS[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ppsu_pkg::ATAN_TURNS[i]);
			end
		end
		ly = (y * longint'(ppsu_pkg::CORDIC_GAIN_Q24) + (64'sd1 <<< 23)) >>> 24;
		num = 2 * longint'({40'd0, axle_distance_q}) * ly;
		steer = 0;
		if (d2 != 0 && num != 0) begin
			a = num < 0 ? 64'(-num) : 64'(num);
			b = d2;
			while (a >= 64'd1 << 30 || b >= 64'd1 << 30) begin
				a >>= 1;
				b >>= 1;
			end
			x = longint'(b);
			y = num < 0 ? -longint'(a) : longint'(a);
			z = 0;
			for (int i = 0; i < STAGES && i < ppsu_pkg::ATAN_LEN; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y < 0) begin
					x -= ys; y += xs; z -= longint'(ppsu_pkg::ATAN_TURNS[i]);
				end else begin
					x += ys; y -= xs; z += longint'(ppsu_pkg::ATAN_TURNS[i]);
				end
			end
			steer = (z + 32768) >>> 16;
			if (steer > 16384) steer = 16384;
			if (steer < -16384) steer = -16384;
		end
		c.speed = c.at_goal ? 24'd0 : cruise_speed_q;
		c.steer = steer[15:0];
		return c;
	endfunction

	// One APB write: setup cycle, then access cycle; the register takes it at the
	// edge that closes the access cycle.
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			ppsu_pkg::REG_STOP_RADIUS: stop_radius_q = val[23:0];
			ppsu_pkg::REG_CRUISE_SPEED: cruise_speed_q = val[23:0];
			ppsu_pkg::REG_AXLE_DISTANCE: axle_distance_q = val[23:0];
			default: ;
		endcase
	endtask

	// Offers one item, holds it until the transfer, then queues what it should produce.
	task automatic send_pose(logic [143:0] d, bit typed, steer_cmd_t cmd);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		pending_cmds.push_back(typed ? cmd : steer_predict(d));
		sent++;
	endtask

	// Waits out the pipeline so the registers can be rewritten safely.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [143:0] random_pose();
		logic [31:0] px, py, ox, oy, r;
		px = $urandom;
		py = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// Goals around the stop radius, where at_goal flips.
				r = {8'd0, stop_radius_q} + 32'd1;
				if (r > 32'd4000000) r = 32'd4000000;
				ox = $urandom_range(0, 2 * r) - r;
				oy = $urandom_range(0, 2 * r) - r;
				if ($urandom_range(0, 7) == 0) oy = 0;
			end
			4, 5: begin
				ox = $urandom_range(0, 32'h200000) - 32'h100000;
				oy = $urandom_range(0, 32'h200000) - 32'h100000;
			end
			6, 7, 8: return {16'($urandom), 32'($urandom), 32'($urandom), px, py};
			default: begin
				ox = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				oy = $urandom_range(0, 1) ? 32'h80000000 : 32'h0;
				return {16'($urandom), py, px, oy, ox};
			end
		endcase
		return {16'($urandom), py, px, py + oy, px + ox};
	endfunction

	// Compare every result transfer with the oldest pending command.
	always @(posedge clk) begin
		steer_cmd_t want;
		if (m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %h", $realtime, m_tdata);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				checked++;
				if (m_tdata[40]) at_goal_seen++;
				if (m_tdata[23:0] !== want.speed) begin
					$display("%0t: speed_cmd expected %h actual %h", $realtime, want.speed,
						m_tdata[23:0]);
					errors++;
				end
				if (m_tdata[39:24] !== want.steer) begin
					$display("%0t: steer_angle expected %0d actual %0d", $realtime,
						want.steer, $signed(m_tdata[39:24]));
					errors++;
				end
				if (m_tdata[40] !== want.at_goal) begin
					$display("%0t: at_goal expected %b actual %b", $realtime, want.at_goal,
						m_tdata[40]);
					errors++;
				end
			end
		end
	end

	// Receiver: random bursts of ready and stall, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	initial begin
		#20ms;
		$display("** pure_pursuit_steering_unit: FAILED **");
		$finish;
	end

	initial begin
		pose_row_t rows[$];
		pose_row_t row;
		steer_cmd_t none;
		none = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, all under the reset register values.
		row.typed = 0; row.cmd = none;
		// Zero offset: stopped, straight ahead, at the goal.
		row.gx = 0; row.gy = 0; row.px = 0; row.py = 0; row.hd = 0;
		row.typed = 1; row.cmd = '{24'd0, 16'sd0, 1'b1}; rows.push_back(row);
		row.gx = 32'h7fffffff; row.gy = 32'h80000000; row.px = 32'h7fffffff;
		row.py = 32'h80000000; row.hd = 16'h7fff; rows.push_back(row);
		row.typed = 0;
		// Offsets that saturate in both directions.
		row.gx = 32'h7fffffff; row.gy = 32'h7fffffff; row.px = 32'h80000000;
		row.py = 32'h80000000; row.hd = 16'h0000; rows.push_back(row);
		row.gx = 32'h80000000; row.gy = 32'h80000000; row.px = 32'h7fffffff;
		row.py = 32'h7fffffff; row.hd = 16'h8000; rows.push_back(row);
		row.gx = 32'h80000000; row.gy = 32'h7fffffff; row.px = 32'h7fffffff;
		row.py = 32'h80000000; row.hd = 16'h7fff; rows.push_back(row);
		// Goal ahead, left, right and behind at several headings.
		row.px = 0; row.py = 0;
		row.gx = 32'd655360; row.gy = 0; row.hd = 0; rows.push_back(row);
		row.gx = 0; row.gy = 32'd655360; row.hd = 0; rows.push_back(row);
		row.gx = 0; row.gy = -32'sd655360; row.hd = 0; rows.push_back(row);
		row.gx = 32'd655360; row.gy = 0; row.hd = 16'h4000; rows.push_back(row);
		row.gx = -32'sd655360; row.gy = 32'd1; row.hd = 16'hc000; rows.push_back(row);
		row.gx = -32'sd655360; row.gy = 0; row.hd = 16'h8000; rows.push_back(row);
		row.gx = 32'd100; row.gy = 32'd1; row.hd = 16'h8001; rows.push_back(row);
		// Either side of the stop radius.
		row.gx = 32'd6553; row.gy = 0; row.hd = 16'h1234; rows.push_back(row);
		row.gx = 32'd6554; row.gy = 0; row.hd = 16'h1234; rows.push_back(row);
		row.gx = 32'd4634; row.gy = 32'd4634; row.hd = 0; rows.push_back(row);
		foreach (rows[i])
			send_pose({rows[i].hd, rows[i].py, rows[i].px, rows[i].gy, rows[i].gx},
				rows[i].typed, rows[i].cmd);

		// Random phases, each under its own register setting. The sender pauses
		// until every pending result has arrived before each rewrite.
		for (int phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				1: begin
					reg_write(ppsu_pkg::REG_STOP_RADIUS, 32'h0);
					reg_write(ppsu_pkg::REG_CRUISE_SPEED, 32'h0);
					reg_write(ppsu_pkg::REG_AXLE_DISTANCE, 32'h0);
				end
				2: begin
					reg_write(ppsu_pkg::REG_STOP_RADIUS, 32'hffffffff);
					reg_write(ppsu_pkg::REG_CRUISE_SPEED, 32'hffffffff);
					reg_write(ppsu_pkg::REG_AXLE_DISTANCE, 32'hffffffff);
					reg_write(REG_UNUSED, $urandom);
				end
				3: begin
					reg_write(ppsu_pkg::REG_STOP_RADIUS, $urandom_range(1, 32'h40000));
					reg_write(ppsu_pkg::REG_CRUISE_SPEED, $urandom);
					reg_write(ppsu_pkg::REG_AXLE_DISTANCE, $urandom_range(1, 32'h80000));
				end
				4: begin
					reg_write(ppsu_pkg::REG_STOP_RADIUS, 32'd1);
					reg_write(ppsu_pkg::REG_CRUISE_SPEED, $urandom);
					reg_write(ppsu_pkg::REG_AXLE_DISTANCE, 32'd1);
					quiet = 1'b1;
				end
				default: ;
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// The long stall makes the pipeline fill while items keep coming.
				if (phase == 0 && n == 100) hold_req = 1'b1;
				send_pose(random_pose(), 0, none);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (pending_cmds.size() != 0) errors++;
		$display("Sent %0d goal/pose items over 5 register settings; checked %0d commands,",
			sent, checked);
		$display("%0d of them at the goal; %0d mismatches.", at_goal_seen, errors);
		if (errors == 0) begin
			$display("** pure_pursuit_steering_unit: PASSED **");
		end else begin
			$display("** pure_pursuit_steering_unit: FAILED **");
		end
		$finish;
	end
endmodule
